[hdl/console_line_editor_unit_assert.svh]
// ----------------------------------------------------------------------------
// Console line editor: assertion macros
// Shorthand for the concurrent checks at the end of the editor module.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDITOR_UNIT_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_UNIT_ASSERT_SVH

// Condition that must hold in every cycle out of reset.
`define CLE_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define CLE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cle_pkg.sv]
// ----------------------------------------------------------------------------
// Console line editor package
// Character codes, command table and shared types of the line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int NUM_CMDS = 5;
  localparam int CMD_MAX  = 6;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7F;

  typedef enum logic [2:0] {
    CMD_EMPTY   = 3'd0,
    CMD_ASSIST  = 3'd1,
    CMD_CLS     = 3'd2,
    CMD_SP      = 3'd3,
    CMD_RESTART = 3'd4,
    CMD_EXIT    = 3'd5,
    CMD_UNKNOWN = 3'd6
  } cmd_code_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_STORE,
    ACT_ERASE,
    ACT_NEWLINE
  } act_t;

  // Command texts, in the order of their codes (table entry i has code i + 1).
  localparam logic [7:0] CMD_TEXT [NUM_CMDS][CMD_MAX] = '{
    '{"h", "e", "l", "p", 8'h00, 8'h00},
    '{"c", "l", "s", 8'h00, 8'h00, 8'h00},
    '{"s", "p", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "b", "o", "o", "t"},
    '{"e", "x", "i", "t", 8'h00, 8'h00}
  };

  localparam logic [2:0] CMD_LEN [NUM_CMDS] = '{3'd4, 3'd3, 3'd2, 3'd6, 3'd4};

  // One line-store entry: the character and, for each command, whether the
  // characters before it match that command's prefix.
  typedef struct packed {
    logic [NUM_CMDS-1:0] match;
    logic [7:0]          ch;
  } entry_t;

  // Byte of a command text at a position; zero past the end of every text.
  function automatic logic [7:0] cmd_byte(input int unsigned idx, input logic [7:0] pos);
    logic [7:0] b;
    b = 8'h00;
    if (pos < 8'(CMD_MAX)) begin
      b = CMD_TEXT[idx][pos[2:0]];
    end
    return b;
  endfunction

endpackage

[hdl/console_line_editor_unit.sv]
// ----------------------------------------------------------------------------
// Console line editor
// Serial console line buffer with echo generation and command recognition.
// ----------------------------------------------------------------------------
// Input stream: one received character per word on s_tdata. NUL is ignored,
// tab is stored as a space, backspace and DEL erase the last character, and
// newline closes the line. Ordinary characters are stored while fewer than
// BUFFER_BYTES - 1 are held; beyond that they are dropped silently.
// Output stream: echo words. A stored character gives one word, an erase gives
// backspace, space, backspace (m_tlast on the third), and a newline gives one
// word with line_done set and the recognised command code.
// The line lives in a single-port-read, single-port-write memory whose entries
// also carry running prefix-match flags, so a command is known in the cycle
// after its newline is accepted, from a single read of the last entry.
// Flow: an accepted character passes the second stage and then the output
// register before m_tvalid rises. One character is taken per cycle while
// s_tready is high and echoes drain one word per cycle while m_tready is
// high; an erase echoes three words, so the output register is the limit.
// Reset clears the line length and empties the pipeline; the memory is left
// as it is. When the receiver stalls, the output register and the stage before
// it hold, and s_tready falls once both are occupied.
// ----------------------------------------------------------------------------
module console_line_editor_unit #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] echo_char, [8] line_done, [11:9] command_code
  output logic        m_tlast
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam logic [AW-1:0] LEN_MAX = AW'(BUFFER_BYTES - 1);

  // Front end: decode and length bookkeeping.
  logic [AW-1:0]      line_length;
  logic [AW-1:0]      line_length_next;
  cle_pkg::act_t      act;
  logic [7:0]         store_ch;
  logic               accept;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  // Second stage: memory read data available.
  logic               s1_valid;
  cle_pkg::act_t      s1_act;
  logic [7:0]         s1_ch;
  logic [AW-1:0]      s1_pos;
  logic [AW-1:0]      s1_prev;
  logic               s1_adv;

  cle_pkg::entry_t    mem [BUFFER_BYTES];
  cle_pkg::entry_t    rd_data;
  cle_pkg::entry_t    rd_word;
  cle_pkg::entry_t    wr_data;
  logic               wr_en;
  logic               last_wr_valid;
  logic [AW-1:0]      last_wr_addr;
  cle_pkg::entry_t    last_wr_data;
  logic               fwd_hit;
  logic [cle_pkg::NUM_CMDS-1:0] ext;
  cle_pkg::cmd_code_t s1_code;

  // Output register.
  logic               out_valid;
  cle_pkg::act_t      out_act;
  logic [7:0]         out_ch;
  cle_pkg::cmd_code_t out_code;
  logic [1:0]         out_step;
  logic               out_final;
  logic               out_free;
  logic [7:0]         echo_char;
  logic               line_done;
  cle_pkg::cmd_code_t command_code;

  // --------------------------------------------------------------------------
  // Decode
  // --------------------------------------------------------------------------
  always_comb begin
    store_ch = (s_tdata == cle_pkg::CH_TAB) ? cle_pkg::CH_SP : s_tdata;
    case (s_tdata)
      cle_pkg::CH_NUL: begin
        act = cle_pkg::ACT_NONE;
      end
      cle_pkg::CH_NL: begin
        act = cle_pkg::ACT_NEWLINE;
      end
      cle_pkg::CH_BS, cle_pkg::CH_DEL: begin
        act = (line_length != '0) ? cle_pkg::ACT_ERASE : cle_pkg::ACT_NONE;
      end
      default: begin
        act = (line_length < LEN_MAX) ? cle_pkg::ACT_STORE : cle_pkg::ACT_NONE;
      end
    endcase
  end

  assign out_final = m_tready && out_valid &&
                     (out_act != cle_pkg::ACT_ERASE || out_step == 2'd2);
  assign out_free  = !out_valid || out_final;
  assign s1_adv    = s1_valid && out_free;
  assign s_tready  = !s1_valid || out_free;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    line_length_next = line_length;
    if (accept) begin
      case (act)
        cle_pkg::ACT_STORE:   line_length_next = line_length + AW'(1);
        cle_pkg::ACT_ERASE:   line_length_next = line_length - AW'(1);
        cle_pkg::ACT_NEWLINE: line_length_next = '0;
        default:              line_length_next = line_length;
      endcase
    end
  end

  // The entry just below the current length is read for every accepted word
  // with a non-empty line; only stores and newlines use it.
  assign rd_en   = accept && (line_length != '0);
  assign rd_addr = line_length - AW'(1);

  // --------------------------------------------------------------------------
  // Match logic on the read entry
  // --------------------------------------------------------------------------
  assign s1_prev = s1_pos - AW'(1);
  assign fwd_hit = last_wr_valid && (last_wr_addr == s1_prev);
  assign rd_word = fwd_hit ? last_wr_data : rd_data;

  always_comb begin
    for (int i = 0; i < cle_pkg::NUM_CMDS; i++) begin
      ext[i] = (s1_pos == '0) ||
               (rd_word.match[i] && rd_word.ch == cle_pkg::cmd_byte(i, 8'(s1_prev)));
    end
  end

  always_comb begin
    s1_code = (s1_pos == '0) ? cle_pkg::CMD_EMPTY : cle_pkg::CMD_UNKNOWN;
    if (s1_pos != '0) begin
      for (int i = cle_pkg::NUM_CMDS - 1; i >= 0; i--) begin
        if (ext[i] && 8'(s1_pos) == 8'(cle_pkg::CMD_LEN[i])) begin
          s1_code = cle_pkg::cmd_code_t'(3'(i + 1));
        end
      end
    end
  end

  assign wr_en         = s1_adv && (s1_act == cle_pkg::ACT_STORE);
  assign wr_data.match = ext;
  assign wr_data.ch    = s1_ch;

  // --------------------------------------------------------------------------
  // Line store
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_pos] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length   <= '0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      out_step      <= 2'd0;
      last_wr_valid <= 1'b0;
    end else begin
      line_length <= line_length_next;
      if (s_tready) begin
        s1_valid <= accept && (act != cle_pkg::ACT_NONE);
      end
      if (wr_en) begin
        last_wr_valid <= 1'b1;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
        out_step  <= 2'd0;
      end else if (out_final) begin
        out_valid <= 1'b0;
        out_step  <= 2'd0;
      end else if (m_tready && out_valid) begin
        out_step <= out_step + 2'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act <= act;
      s1_ch  <= store_ch;
      s1_pos <= line_length;
    end
    if (wr_en) begin
      last_wr_addr <= s1_pos;
      last_wr_data <= wr_data;
    end
    if (s1_adv) begin
      out_act  <= s1_act;
      out_ch   <= s1_ch;
      out_code <= s1_code;
    end
  end

  // --------------------------------------------------------------------------
  // Output word
  // --------------------------------------------------------------------------
  always_comb begin
    echo_char    = out_ch;
    line_done    = 1'b0;
    command_code = cle_pkg::CMD_EMPTY;
    m_tlast      = 1'b1;
    case (out_act)
      cle_pkg::ACT_ERASE: begin
        echo_char = (out_step == 2'd1) ? cle_pkg::CH_SP : cle_pkg::CH_BS;
        m_tlast   = (out_step == 2'd2);
      end
      cle_pkg::ACT_NEWLINE: begin
        echo_char    = cle_pkg::CH_NL;
        line_done    = 1'b1;
        command_code = out_code;
      end
      default: begin
        echo_char = out_ch;
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, command_code, line_done, echo_char};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `include "console_line_editor_unit_assert.svh"

  `CLE_ASSERT_ALWAYS(a_len_bound, line_length <= LEN_MAX, "line length beyond buffer bound")
  `CLE_ASSERT_NEXT(a_nl_clear, accept && act == cle_pkg::ACT_NEWLINE, line_length == '0, "newline did not clear the line")
  `CLE_ASSERT_NEXT(a_erase_dec, accept && act == cle_pkg::ACT_ERASE, line_length == $past(line_length) - AW'(1), "erase did not shorten the line")
  `CLE_ASSERT_IMPL(a_step_erase, out_valid && out_step != 2'd0, out_act == cle_pkg::ACT_ERASE, "multi-word echo outside an erase")

endmodule
